### hw/rtl/lrg_pkg.sv
// Shared types, constants and the control program of the light-gun report generator.
package lrg_pkg;

    localparam int unsigned STEP_W = 4;

    localparam logic [3:0] HOLD_POLLS = 4'd9;

    localparam int unsigned BIT_TRIGGER   = 13;
    localparam int unsigned BIT_OFFSCREEN = 16;
    localparam int unsigned BIT_RECAL     = 17;
    localparam int unsigned BIT_PROG      = 8;

    localparam logic KIND_POLL = 1'b0;
    localparam logic KIND_SET  = 1'b1;

    localparam logic [2:0] CFG_SCREEN_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_SCREEN_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_CENTER_X      = 3'd2;
    localparam logic [2:0] CFG_CENTER_Y      = 3'd3;
    localparam logic [2:0] CFG_SCALE_X       = 3'd4;
    localparam logic [2:0] CFG_SCALE_Y       = 3'd5;

    typedef logic [1:0] op_t;

    localparam op_t OP_MUL_P = 2'd0;
    localparam op_t OP_MUL_S = 2'd1;
    localparam op_t OP_ADD_C = 2'd2;
    localparam op_t OP_FIN   = 2'd3;

    typedef struct packed {
        op_t              op;
        logic             axis_y;
        logic             last;
        logic             jmp_off;
        logic [STEP_W-1:0] target;
    } ctrl_t;

    localparam logic [STEP_W-1:0] STEP_OUT = 4'd8;

    function automatic ctrl_t prog_word(input logic [STEP_W-1:0] step);
        ctrl_t cw;
        cw = '{op: OP_MUL_P, axis_y: 1'b0, last: 1'b0, jmp_off: 1'b0, target: STEP_OUT};
        unique case (step)
            4'd0:
            begin
                cw.op      = OP_MUL_P;
                cw.jmp_off = 1'b1;
            end
            4'd1: cw.op = OP_MUL_S;
            4'd2: cw.op = OP_ADD_C;
            4'd3: cw.op = OP_FIN;
            4'd4:
            begin
                cw.op     = OP_MUL_P;
                cw.axis_y = 1'b1;
            end
            4'd5:
            begin
                cw.op     = OP_MUL_S;
                cw.axis_y = 1'b1;
            end
            4'd6:
            begin
                cw.op     = OP_ADD_C;
                cw.axis_y = 1'b1;
            end
            4'd7:
            begin
                cw.op     = OP_FIN;
                cw.axis_y = 1'b1;
            end
            default: cw.last = 1'b1;
        endcase
        return cw;
    endfunction

endpackage

### hw/rtl/lrg_datapath.sv
// Shared multiplier datapath that maps one pointer axis to a clamped screen coordinate.
module lrg_datapath
    import lrg_pkg::*;
(
    input  logic               clk,
    input  ctrl_t              cw,
    input  logic               run,
    input  logic [16:0]        px,
    input  logic [16:0]        py,
    input  logic [10:0]        width,
    input  logic [10:0]        height,
    input  logic [18:0]        ctr_x,
    input  logic [18:0]        ctr_y,
    input  logic [15:0]        scl_x,
    input  logic [15:0]        scl_y,
    input  logic signed [15:0] off_x,
    input  logic signed [15:0] off_y,
    input  logic               prog,
    output logic signed [15:0] res_x,
    output logic signed [15:0] res_y
);

    logic signed [45:0] prod_reg;
    logic signed [46:0] num_reg;
    logic signed [15:0] res_x_reg;
    logic signed [15:0] res_y_reg;

    logic [16:0]        p_sel;
    logic [10:0]        size_sel;
    logic [18:0]        ctr_sel;
    logic [15:0]        scl_sel;
    logic signed [15:0] off_sel;
    logic signed [28:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [45:0] mul_p;
    logic signed [46:0] num_next;
    logic signed [46:0] bias;
    logic signed [46:0] rsum;
    logic signed [16:0] rnd;
    logic signed [15:0] adj;
    logic signed [17:0] diff;
    logic signed [15:0] clamped;

    always_comb
    begin
        p_sel    = cw.axis_y ? py     : px;
        size_sel = cw.axis_y ? height : width;
        ctr_sel  = cw.axis_y ? ctr_y  : ctr_x;
        scl_sel  = cw.axis_y ? scl_y  : scl_x;
        off_sel  = cw.axis_y ? off_y  : off_x;

        if (cw.op == OP_MUL_S)
        begin
            mul_a = $signed(prod_reg[28:0] - {3'b0, size_sel[10:1], 16'b0});
            mul_b = $signed({1'b0, scl_sel});
        end
        else
        begin
            mul_a = $signed({12'b0, p_sel});
            mul_b = $signed({6'b0, size_sel});
        end
        mul_p = mul_a * mul_b;

        num_next = $signed({prod_reg[45], prod_reg}) + $signed({6'b0, ctr_sel, 22'b0});

        // round half away from zero: bias one less when negative, then floor
        bias    = num_reg[46] ? 47'sh1FFF_FFFF : 47'sh2000_0000;
        rsum    = num_reg + bias;
        rnd     = rsum[46:30];
        adj     = prog ? ((off_sel + $signed({15'b0, off_sel[15]})) >>> 1) : off_sel;
        diff    = $signed({rnd[16], rnd}) - $signed({{2{adj[15]}}, adj});
        if (diff < 18'sd1)
            clamped = 16'sd1;
        else if (diff > 18'sd32767)
            clamped = 16'sd32767;
        else
            clamped = diff[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (run)
        begin
            case (cw.op)
                OP_MUL_P, OP_MUL_S: prod_reg <= mul_p;
                OP_ADD_C:           num_reg  <= num_next;
                default:
                begin
                    if (cw.axis_y)
                        res_y_reg <= clamped;
                    else
                        res_x_reg <= clamped;
                end
            endcase
        end
    end

    assign res_x = res_x_reg;
    assign res_y = res_y_reg;

endmodule

### hw/rtl/lightgun_report_generator.sv
// Top level of the light-gun report generator: handshake, microcode sequencer, hold state.
//
// A set write (kind 1) yields no report. A report poll runs a nine-step microprogram after
// acceptance: four steps per axis through one shared multiplier (pointer times size,
// offset-corrected product times scale, add center, round/offset/clamp) and one output
// step, so a poll busies the block for all nine steps, or only the first and the output
// step when the pointer is off-screen. A finished report sits in an output register, so
// the next item is taken while it waits; the output step stalls only if the previous
// report is still untaken. Configuration writes are taken every cycle.
module lightgun_report_generator
    import lrg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [18:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               kind,
    input  logic signed [17:0] aim_x,
    input  logic signed [17:0] aim_y,
    input  logic [17:0]        buttons,
    input  logic signed [15:0] new_offset_x,
    input  logic signed [15:0] new_offset_y,
    input  logic [15:0]        new_mode,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [15:0]        report_buttons,
    output logic signed [15:0] report_x,
    output logic signed [15:0] report_y
);

    logic [10:0]        width_reg;
    logic [10:0]        height_reg;
    logic [18:0]        ctr_x_reg;
    logic [18:0]        ctr_y_reg;
    logic [15:0]        scl_x_reg;
    logic [15:0]        scl_y_reg;
    logic signed [15:0] off_x_reg;
    logic signed [15:0] off_y_reg;
    logic [15:0]        mode_reg;
    logic [3:0]         hold_reg;
    logic [3:0]         hold_next;
    logic signed [15:0] held_x_reg;
    logic signed [15:0] held_x_next;
    logic signed [15:0] held_y_reg;
    logic signed [15:0] held_y_next;

    logic               busy_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [16:0]        px_reg;
    logic [16:0]        py_reg;
    logic [17:0]        btn_reg;
    logic               offscr_reg;

    logic               out_valid_reg;
    logic [15:0]        rb_reg;
    logic [15:0]        rb_next;
    logic signed [15:0] rx_reg;
    logic signed [15:0] rx_next;
    logic signed [15:0] ry_reg;
    logic signed [15:0] ry_next;

    ctrl_t              cw;
    logic               in_acc;
    logic               out_free;
    logic               emit;
    logic signed [15:0] res_x;
    logic signed [15:0] res_y;
    logic signed [15:0] cx;
    logic signed [15:0] cy;

    assign cfg_ready = 1'b1;
    assign in_ready  = !busy_reg;
    assign in_acc    = in_valid && in_ready;
    assign cw        = prog_word(step_reg);
    assign out_free  = !out_valid_reg || out_ready;
    assign emit      = busy_reg && cw.last && out_free;

    lrg_datapath u_dp (
        .clk    (clk),
        .cw     (cw),
        .run    (busy_reg && !cw.last),
        .px     (px_reg),
        .py     (py_reg),
        .width  (width_reg),
        .height (height_reg),
        .ctr_x  (ctr_x_reg),
        .ctr_y  (ctr_y_reg),
        .scl_x  (scl_x_reg),
        .scl_y  (scl_y_reg),
        .off_x  (off_x_reg),
        .off_y  (off_y_reg),
        .prog   (mode_reg[BIT_PROG]),
        .res_x  (res_x),
        .res_y  (res_y)
    );

    always_comb
    begin
        cx          = offscr_reg ? 16'sd0 : res_x;
        cy          = offscr_reg ? 16'sd0 : res_y;
        hold_next   = hold_reg;
        held_x_next = held_x_reg;
        held_y_next = held_y_reg;
        if (btn_reg[BIT_RECAL] && hold_reg == 4'd0)
        begin
            hold_next   = HOLD_POLLS;
            held_x_next = cx;
            held_y_next = cy;
        end
        rb_next = ~btn_reg[15:0] | (mode_reg & (16'd1 << BIT_PROG));
        rx_next = cx;
        ry_next = cy;
        if (hold_next != 4'd0)
        begin
            rb_next[BIT_TRIGGER] = 1'b0;
            hold_next            = hold_next - 4'd1;
            rx_next              = (hold_next == 4'd0) ? 16'sd0 : held_x_next;
            ry_next              = (hold_next == 4'd0) ? 16'sd0 : held_y_next;
        end
        else if (btn_reg[BIT_OFFSCREEN])
        begin
            rb_next[BIT_TRIGGER] = 1'b0;
            rx_next              = 16'sd0;
            ry_next              = 16'sd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= 11'd640;
            height_reg    <= 11'd240;
            ctr_x_reg     <= 19'd81920;
            ctr_y_reg     <= 19'd30720;
            scl_x_reg     <= 16'd16384;
            scl_y_reg     <= 16'd16384;
            off_x_reg     <= '0;
            off_y_reg     <= '0;
            mode_reg      <= '0;
            hold_reg      <= '0;
            held_x_reg    <= '0;
            held_y_reg    <= '0;
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SCREEN_WIDTH:  width_reg  <= cfg_data[10:0];
                    CFG_SCREEN_HEIGHT: height_reg <= cfg_data[10:0];
                    CFG_CENTER_X:      ctr_x_reg  <= cfg_data;
                    CFG_CENTER_Y:      ctr_y_reg  <= cfg_data;
                    CFG_SCALE_X:       scl_x_reg  <= cfg_data[15:0];
                    CFG_SCALE_Y:       scl_y_reg  <= cfg_data[15:0];
                    default:           ;
                endcase
            end

            if (in_acc)
            begin
                if (kind == KIND_SET)
                begin
                    off_x_reg <= new_offset_x;
                    off_y_reg <= new_offset_y;
                    mode_reg  <= new_mode;
                end
                else
                begin
                    busy_reg <= 1'b1;
                    step_reg <= '0;
                end
            end
            else if (busy_reg)
            begin
                if (cw.last)
                begin
                    if (out_free)
                        busy_reg <= 1'b0;
                end
                else if (cw.jmp_off && offscr_reg)
                    step_reg <= cw.target;
                else
                    step_reg <= step_reg + 4'd1;
            end

            if (emit)
            begin
                hold_reg      <= hold_next;
                held_x_reg    <= held_x_next;
                held_y_reg    <= held_y_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && kind == KIND_POLL)
        begin
            px_reg     <= aim_x[16:0];
            py_reg     <= aim_y[16:0];
            btn_reg    <= buttons;
            offscr_reg <= aim_x[17] || aim_y[17] || buttons[BIT_OFFSCREEN];
        end
        if (emit)
        begin
            rb_reg <= rb_next;
            rx_reg <= rx_next;
            ry_reg <= ry_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign report_buttons = rb_reg;
    assign report_x       = rx_reg;
    assign report_y       = ry_reg;

endmodule

### tb/sv/lrg_report_checker.sv
// Scoreboard for the light-gun report generator: tracks state, predicts and checks reports.
module lrg_report_checker
    import lrg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [18:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               kind,
    input  logic signed [17:0] aim_x,
    input  logic signed [17:0] aim_y,
    input  logic [17:0]        buttons,
    input  logic signed [15:0] new_offset_x,
    input  logic signed [15:0] new_offset_y,
    input  logic [15:0]        new_mode,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [15:0]        report_buttons,
    input  logic signed [15:0] report_x,
    input  logic signed [15:0] report_y,
    output int                 mismatches,
    output int                 outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0]        buttons;
        logic signed [15:0] x;
        logic signed [15:0] y;
    } gun_report_t;

    logic [10:0]        width_q;
    logic [10:0]        height_q;
    logic [18:0]        center_x_q;
    logic [18:0]        center_y_q;
    logic [15:0]        scale_x_q;
    logic [15:0]        scale_y_q;
    logic signed [15:0] offset_x_q;
    logic signed [15:0] offset_y_q;
    logic [15:0]        mode_q;
    logic [3:0]         hold_q;
    logic signed [15:0] held_x_q;
    logic signed [15:0] held_y_q;

    gun_report_t expected_reports[$];
    int          mismatch_count = 0;
    int          pending_count  = 0;
    int          reports_seen   = 0;

    assign mismatches  = mismatch_count;
    assign outstanding = pending_count;

    function automatic logic signed [15:0] map_to_screen(input logic signed [17:0] pos,
                                                          input logic [10:0] size,
                                                          input logic [15:0] scale,
                                                          input logic [18:0] center,
                                                          input logic signed [15:0] offset,
                                                          input logic prog);
        longint num;
        longint pix;
        longint shift;
        num = longint'(pos) * longint'(size) * longint'(scale)
            - longint'(size >> 1) * longint'(scale) * 65536
            + longint'(center) * 4194304;
        if (num >= 0)
            pix = (num + 536870912) >>> 30;
        else
            pix = -((-num + 536870912) >>> 30);
        shift = prog ? longint'(offset) / 2 : longint'(offset);
        pix = pix - shift;
        if (pix < 1)
            pix = 1;
        if (pix > 32767)
            pix = 32767;
        return 16'(pix);
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        $display("%0t ns  report %0d: %s", $time, reports_seen, msg);
    endtask

    task automatic predict_poll();
        gun_report_t        rep;
        logic signed [15:0] x;
        logic signed [15:0] y;
        if (aim_x[17] || aim_y[17] || buttons[BIT_OFFSCREEN])
        begin
            x = '0;
            y = '0;
        end
        else
        begin
            x = map_to_screen(aim_x, width_q, scale_x_q, center_x_q, offset_x_q,
                              mode_q[BIT_PROG]);
            y = map_to_screen(aim_y, height_q, scale_y_q, center_y_q, offset_y_q,
                              mode_q[BIT_PROG]);
        end
        if (buttons[BIT_RECAL] && hold_q == 4'd0)
        begin
            hold_q   = HOLD_POLLS;
            held_x_q = x;
            held_y_q = y;
        end
        rep.buttons = ~buttons[15:0];
        rep.buttons[BIT_PROG] = rep.buttons[BIT_PROG] | mode_q[BIT_PROG];
        if (hold_q != 4'd0)
        begin
            rep.buttons[BIT_TRIGGER] = 1'b0;
            x = held_x_q;
            y = held_y_q;
            hold_q = hold_q - 4'd1;
            if (hold_q == 4'd0)
            begin
                x = '0;
                y = '0;
            end
        end
        else if (buttons[BIT_OFFSCREEN])
        begin
            rep.buttons[BIT_TRIGGER] = 1'b0;
            x = '0;
            y = '0;
        end
        rep.x = x;
        rep.y = y;
        expected_reports.push_back(rep);
    endtask

    task automatic check_report();
        gun_report_t want;
        reports_seen++;
        if (expected_reports.size() == 0)
        begin
            flag_mismatch($sformatf("beat with nothing pending: buttons %h x %0d y %0d",
                                    report_buttons, report_x, report_y));
        end
        else
        begin
            want = expected_reports.pop_front();
            if (report_buttons !== want.buttons)
                flag_mismatch($sformatf("buttons %h, want %h", report_buttons, want.buttons));
            if (report_x !== want.x)
                flag_mismatch($sformatf("x %0d, want %0d", report_x, want.x));
            if (report_y !== want.y)
                flag_mismatch($sformatf("y %0d, want %0d", report_y, want.y));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_q    = 11'd640;
            height_q   = 11'd240;
            center_x_q = 19'd81920;
            center_y_q = 19'd30720;
            scale_x_q  = 16'd16384;
            scale_y_q  = 16'd16384;
            offset_x_q = '0;
            offset_y_q = '0;
            mode_q     = '0;
            hold_q     = '0;
            held_x_q   = '0;
            held_y_q   = '0;
            expected_reports.delete();
            pending_count = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SCREEN_WIDTH:  width_q    = cfg_data[10:0];
                    CFG_SCREEN_HEIGHT: height_q   = cfg_data[10:0];
                    CFG_CENTER_X:      center_x_q = cfg_data;
                    CFG_CENTER_Y:      center_y_q = cfg_data;
                    CFG_SCALE_X:       scale_x_q  = cfg_data[15:0];
                    CFG_SCALE_Y:       scale_y_q  = cfg_data[15:0];
                    default:           ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                if (kind == KIND_SET)
                begin
                    offset_x_q = new_offset_x;
                    offset_y_q = new_offset_y;
                    mode_q     = new_mode;
                end
                else
                begin
                    predict_poll();
                end
            end
            if (out_valid && out_ready)
                check_report();
            pending_count = expected_reports.size();
        end
    end

endmodule

### tb/sv/tb_top.sv
// Top of the light-gun report generator testbench: clock, reset, stimulus and verdict.
module tb_top;
    import lrg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] CFG_SPARE_A      = 3'd6;
    localparam logic [2:0] CFG_SPARE_B      = 3'd7;
    localparam int         RANDOM_PER_SETUP = 125;
    localparam int         WATCHDOG_LIMIT   = 4000;

    typedef struct {
        logic        kind;
        logic [17:0] px;
        logic [17:0] py;
        logic [17:0] btn;
        logic [15:0] ox;
        logic [15:0] oy;
        logic [15:0] mode;
    } gun_item_t;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               cfg_valid    = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index    = '0;
    logic [18:0]        cfg_data     = '0;
    logic               in_valid     = 1'b0;
    logic               in_ready;
    logic               kind         = KIND_POLL;
    logic signed [17:0] aim_x        = '0;
    logic signed [17:0] aim_y        = '0;
    logic [17:0]        buttons      = '0;
    logic signed [15:0] new_offset_x = '0;
    logic signed [15:0] new_offset_y = '0;
    logic [15:0]        new_mode     = '0;
    logic               out_valid;
    logic               out_ready    = 1'b0;
    logic [15:0]        report_buttons;
    logic signed [15:0] report_x;
    logic signed [15:0] report_y;

    int mismatches;
    int outstanding;
    int tx_idle_pct  = 29;
    int rx_stall_pct = 72;
    int quiet_cycles = 0;
    int polls_sent   = 0;
    int sets_sent    = 0;
    int setups       = 0;

    lightgun_report_generator u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .aim_x          (aim_x),
        .aim_y          (aim_y),
        .buttons        (buttons),
        .new_offset_x   (new_offset_x),
        .new_offset_y   (new_offset_y),
        .new_mode       (new_mode),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .report_buttons (report_buttons),
        .report_x       (report_x),
        .report_y       (report_y)
    );

    lrg_report_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .aim_x          (aim_x),
        .aim_y          (aim_y),
        .buttons        (buttons),
        .new_offset_x   (new_offset_x),
        .new_offset_y   (new_offset_y),
        .new_mode       (new_mode),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .report_buttons (report_buttons),
        .report_x       (report_x),
        .report_y       (report_y),
        .mismatches     (mismatches),
        .outstanding    (outstanding)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic gun_item_t poll_item(input logic [17:0] px, input logic [17:0] py,
                                            input logic [17:0] btn);
        gun_item_t it;
        it = '{kind: KIND_POLL, px: px, py: py, btn: btn, ox: '0, oy: '0, mode: '0};
        return it;
    endfunction

    function automatic gun_item_t set_item(input logic [15:0] ox, input logic [15:0] oy,
                                           input logic [15:0] mode);
        gun_item_t it;
        it = '{kind: KIND_SET, px: '0, py: '0, btn: '0, ox: ox, oy: oy, mode: mode};
        return it;
    endfunction

    function automatic logic [17:0] pick_coord();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 18'($urandom_range(0, 65536));
        else if (roll < 75)
            return 18'($urandom_range(0, 131071));
        else if (roll < 88)
            return 18'($urandom);
        else
            return 18'($urandom_range(131072, 262143));
    endfunction

    function automatic logic [15:0] pick_offset();
        if ($urandom_range(0, 1) != 0)
            return 16'($urandom);
        else
            return 16'(int'($urandom_range(0, 800)) - 400);
    endfunction

    function automatic gun_item_t random_item();
        gun_item_t it;
        it.kind = ($urandom_range(0, 99) < 10) ? KIND_SET : KIND_POLL;
        it.px   = pick_coord();
        it.py   = pick_coord();
        it.btn  = 18'($urandom_range(0, 65535));
        it.btn[BIT_OFFSCREEN] = ($urandom_range(0, 99) < 8);
        it.btn[BIT_RECAL]     = ($urandom_range(0, 99) < 6);
        it.ox   = pick_offset();
        it.oy   = pick_offset();
        it.mode = 16'($urandom);
        return it;
    endfunction

    task automatic send_item(input gun_item_t it);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        kind         <= it.kind;
        aim_x        <= it.px;
        aim_y        <= it.py;
        buttons      <= it.btn;
        new_offset_x <= it.ox;
        new_offset_y <= it.oy;
        new_mode     <= it.mode;
        in_valid     <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (it.kind == KIND_SET)
            sets_sent++;
        else
            polls_sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [18:0] data);
        cfg_index <= index;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic load_setting(input int which);
        int v[6];
        case (which)
            0:       v = '{1, 1024, 0, 262144, 0, 65535};
            1:       v = '{640, 240, 81920, 30720, 16384, 16384};
            2:       v = '{1024, 1, 262144, 0, 65535, 0};
            4:       v = '{0, 0, 524287, 524287, 32768, 8192};
            5:       v = '{2047, 2047, 40960, 131072, 20000, 12000};
            default: v = '{$urandom_range(1, 1024), $urandom_range(1, 1024),
                           $urandom_range(0, 262144), $urandom_range(0, 262144),
                           $urandom_range(0, 65535), $urandom_range(0, 65535)};
        endcase
        write_reg(CFG_SCREEN_WIDTH, 19'(v[0]));
        write_reg(CFG_SCREEN_HEIGHT, 19'(v[1]));
        write_reg(CFG_CENTER_X, 19'(v[2]));
        write_reg(CFG_CENTER_Y, 19'(v[3]));
        write_reg(CFG_SCALE_X, 19'(v[4]));
        write_reg(CFG_SCALE_Y, 19'(v[5]));
        write_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_A : CFG_SPARE_B, 19'($urandom));
        cfg_valid <= 1'b0;
        setups++;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_item(set_item(16'h0000, 16'h0000, 16'h0000));
        send_item(poll_item(18'd0, 18'd0, 18'h00000));
        send_item(poll_item(18'd65536, 18'd65536, 18'h0FFFF));
        send_item(poll_item(18'd131071, 18'd131071, 18'h02000));
        send_item(poll_item(18'h20000, 18'd1000, 18'h02000));
        send_item(poll_item(18'd1000, 18'h3FFFF, 18'h00000));
        send_item(poll_item(18'd32768, 18'd32768, 18'h12000));
        send_item(set_item(16'h8000, 16'h7FFF, 16'hFFFF));
        send_item(poll_item(18'd32768, 18'd32768, 18'h00000));
        send_item(poll_item(18'd65535, 18'd0, 18'h000AA));
        send_item(set_item(16'h7FFF, 16'h8000, 16'hFEFF));
        send_item(poll_item(18'd32768, 18'd32768, 18'h00000));
        send_item(set_item(16'd12, 16'hFFF9, 16'h0100));
        send_item(poll_item(18'd30000, 18'd40000, 18'h22000));
        for (int i = 0; i < 8; i++)
            send_item(poll_item(18'($urandom_range(0, 65536)), 18'($urandom_range(0, 65536)),
                                (i == 2) ? 18'h22000 : (i == 4) ? 18'h12000 : 18'h02000));
        send_item(poll_item(18'd20000, 18'd20000, 18'h30000));

        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct  = (phase == 0) ? 29 : (phase == 1) ? 72 : 0;
            rx_stall_pct = (phase == 0) ? 72 : (phase == 1) ? 29 : 0;
            for (int half = 0; half < 2; half++)
            begin
                // hold off until every report is back, then let the block settle
                in_valid <= 1'b0;
                wait (outstanding == 0);
                repeat (12) @(negedge clk);
                load_setting(phase * 2 + half);
                repeat (RANDOM_PER_SETUP)
                    send_item(random_item());
            end
        end

        in_valid <= 1'b0;
        wait (outstanding == 0);
        repeat (20) @(posedge clk);

        $display("Ran %0d polls and %0d offset/mode writes over %0d screen setups,",
                 polls_sent, sets_sent, setups + 1);
        $display("with sender and receiver stalls swapped, then none; %0d field mismatches.",
                 mismatches);
        if (mismatches == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
